FILE: src/rstm_pkg.sv
// ----------------------------------------------------------------------------
// rstm_pkg
// shared constants, configuration struct and arctangent table for the
// scan transform merge block
// ----------------------------------------------------------------------------
package rstm_pkg;

    localparam int MAX_BEAMS    = 4096;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;

    localparam int BEAM_W     = $clog2(MAX_BEAMS);
    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int ANGLE_KEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

    localparam logic [15:0] ANGLE_MASK    = 16'(32'hFFFF << (16 - ANGLE_KEEP));
    localparam logic [29:0] GAIN_Q30      = 30'd652032874;
    localparam logic [15:0] RANGE_INVALID = 16'hFFFF;
    localparam logic [15:0] RANGE_TOP     = 16'd65534;

    typedef struct packed {
        logic signed [15:0] rot_xx;
        logic signed [15:0] rot_xy;
        logic signed [15:0] rot_yx;
        logic signed [15:0] rot_yy;
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
    } rstm_xform_cfg_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/rstm_xform.sv
// ----------------------------------------------------------------------------
// rstm_xform
// polar to cartesian, rigid transform and back to range for one beam, on one
// shared cordic step unit and one shared 32x32 multiplier
// ----------------------------------------------------------------------------
module rstm_xform
    import rstm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [15:0]     range_in,
    input  logic [15:0]     angle,
    input  rstm_xform_cfg_t cfg,
    output logic            done,
    output logic [15:0]     result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_LOAD,
        S_ROT,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_VEC,
        S_G0,
        S_G1,
        S_G2
    } state_t;

    localparam logic signed [33:0] Z_QUARTER = 34'sh0_4000_0000;
    localparam logic signed [33:0] Z_HALF    = 34'sh0_8000_0000;
    localparam logic signed [33:0] Z_3Q      = 34'sh0_C000_0000;
    localparam logic signed [33:0] Z_TURN    = 34'sh1_0000_0000;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic signed [35:0]  cx_reg;
    logic signed [35:0]  cy_reg;
    logic signed [33:0]  cz_reg;
    logic signed [63:0]  prod_reg;
    logic signed [63:0]  acc_reg;
    logic signed [35:0]  t_reg;
    logic [15:0]         range_reg;
    logic [15:0]         angle_reg;
    logic [15:0]         result_reg;
    logic                done_reg;

    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic signed [63:0]  mul_p;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_GAIN:
            begin
                mul_a = {4'b0, range_reg, 12'b0};
                mul_b = {2'b0, GAIN_Q30};
            end
            S_M0:
            begin
                mul_a = 32'(cfg.rot_xx);
                mul_b = cx_reg[31:0];
            end
            S_M1:
            begin
                mul_a = 32'(cfg.rot_xy);
                mul_b = cy_reg[31:0];
            end
            S_M2:
            begin
                mul_a = 32'(cfg.rot_yx);
                mul_b = cx_reg[31:0];
            end
            S_M3:
            begin
                mul_a = 32'(cfg.rot_yy);
                mul_b = cy_reg[31:0];
            end
            S_G0:
            begin
                mul_a = {14'b0, cx_reg[17:0]};
                mul_b = {2'b0, GAIN_Q30};
            end
            S_G1:
            begin
                mul_a = {14'b0, cx_reg[35:18]};
                mul_b = {2'b0, GAIN_Q30};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // cordic step unit, shared by rotation and vectoring
    logic               dir;
    logic signed [35:0] sh_x;
    logic signed [35:0] sh_y;
    logic signed [33:0] atan_v;
    logic signed [35:0] step_x;
    logic signed [35:0] step_y;
    logic signed [33:0] step_z;

    always_comb
    begin
        dir    = (state_reg == S_ROT) ? !cz_reg[33] : !(cy_reg > 36'sd0);
        sh_x   = cy_reg >>> step_reg;
        sh_y   = cx_reg >>> step_reg;
        atan_v = signed'({4'b0, atan_turn(5'(step_reg))});
        if (dir)
        begin
            step_x = cx_reg - sh_x;
            step_y = cy_reg + sh_y;
            step_z = cz_reg - atan_v;
        end
        else
        begin
            step_x = cx_reg + sh_x;
            step_y = cy_reg - sh_y;
            step_z = cz_reg + atan_v;
        end
    end

    // phase folding into the right half plane
    logic signed [33:0] z_raw;
    logic signed [33:0] z_wrap;
    logic signed [35:0] x_init;
    logic               fold;

    always_comb
    begin
        z_raw  = signed'({2'b00, angle_reg & ANGLE_MASK, 16'b0});
        z_wrap = (z_raw >= Z_3Q) ? z_raw - Z_TURN : z_raw;
        fold   = (z_wrap >= Z_QUARTER);
        x_init = 36'(prod_reg >>> 30);
    end

    // rigid transform sums
    logic signed [63:0] lin_sum;
    logic signed [35:0] lin_sh;
    logic signed [35:0] tx_val;
    logic signed [35:0] ty_val;

    always_comb
    begin
        lin_sum = acc_reg + prod_reg;
        lin_sh  = 36'(lin_sum >>> 14);
        tx_val  = lin_sh + signed'({{8{cfg.shift_x[15]}}, cfg.shift_x, 12'b0});
        ty_val  = lin_sh + signed'({{8{cfg.shift_y[15]}}, cfg.shift_y, 12'b0});
    end

    // gain correction, rounding and saturation
    logic [67:0] gain_sum;
    logic [37:0] mag;
    logic [38:0] rnd_sum;
    logic [26:0] rnd;
    logic [15:0] sat;

    always_comb
    begin
        gain_sum = (68'(prod_reg[47:0]) << 18) + 68'(acc_reg[47:0]);
        mag      = gain_sum[67:30];
        rnd_sum  = 39'(mag) + 39'd2048;
        rnd      = rnd_sum[38:12];
        sat      = (rnd > 27'(RANGE_TOP)) ? RANGE_TOP : rnd[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_M0;
                    end
                end
                S_M0:
                begin
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    step_reg  <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_G0;
                    end
                end
                S_G0:
                begin
                    state_reg <= S_G1;
                end
                S_G1:
                begin
                    state_reg <= S_G2;
                end
                S_G2:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    range_reg <= range_in;
                    angle_reg <= angle;
                end
            end
            S_LOAD:
            begin
                cx_reg <= fold ? -x_init : x_init;
                cy_reg <= '0;
                cz_reg <= fold ? z_wrap - Z_HALF : z_wrap;
            end
            S_ROT, S_VEC:
            begin
                cx_reg <= step_x;
                cy_reg <= step_y;
                cz_reg <= step_z;
            end
            S_M1, S_M3, S_G1:
            begin
                acc_reg <= prod_reg;
            end
            S_M2:
            begin
                t_reg <= tx_val;
            end
            S_M4:
            begin
                if (t_reg < 36'sd0)
                begin
                    cx_reg <= -t_reg;
                    cy_reg <= -ty_val;
                end
                else
                begin
                    cx_reg <= t_reg;
                    cy_reg <= ty_val;
                end
            end
            S_G2:
            begin
                result_reg <= sat;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_result_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> result_reg != RANGE_INVALID)
        else $error("transformed range above saturation limit");

    a_vector_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_G0) |-> !cx_reg[35])
        else $error("vectoring ended with negative x");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("done raised outside idle");

endmodule

FILE: src/range_scan_transform_merge.sv
// ----------------------------------------------------------------------------
// range_scan_transform_merge
// per-beam merge of a primary range with a rigidly transformed secondary range,
// tracking the closest reading of each scan
// ----------------------------------------------------------------------------
// sequencing: a beam is accepted only in idle, and the next beam waits until its result
//   is registered; a beam whose secondary range is transformed first runs the two
//   16-step cordic passes and 7 multiplier slots on the shared unit, other beams go
//   straight to the finish state; a result held by the receiver stalls the beam in
//   its finish state and so holds off the next beam
// reset: registers return to identity transform, zero angles, empty scan
module range_scan_transform_merge
    import rstm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // aux_range[15:0], main_range[31:16]
    input  logic        s_tuser,   // aux_present
    input  logic        s_tlast,   // beam_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // merged_range[15:0], nearest_range[31:16],
                                   // nearest_angle[47:32]
    output logic        m_tlast,   // scan_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [3:0] REG_ANGLE_START = 4'd0;
    localparam logic [3:0] REG_ANGLE_STEP  = 4'd1;
    localparam logic [3:0] REG_ROT_XX      = 4'd2;
    localparam logic [3:0] REG_ROT_XY      = 4'd3;
    localparam logic [3:0] REG_ROT_YX      = 4'd4;
    localparam logic [3:0] REG_ROT_YY      = 4'd5;
    localparam logic [3:0] REG_SHIFT_X     = 4'd6;
    localparam logic [3:0] REG_SHIFT_Y     = 4'd7;

    localparam logic [15:0]       ONE_Q14   = 16'd16384;
    localparam logic [BEAM_W-1:0] BEAM_LAST = BEAM_W'(MAX_BEAMS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_FINISH
    } state_t;

    state_t            state_reg;
    rstm_xform_cfg_t   xcfg_reg;
    logic [15:0]       angle_start_reg;
    logic [15:0]       angle_step_reg;
    logic [BEAM_W-1:0] beam_count_reg;
    logic [15:0]       beam_angle_reg;
    logic [15:0]       best_range_reg;
    logic [15:0]       best_angle_reg;
    logic [15:0]       main_reg;
    logic [15:0]       aux_t_reg;
    logic              use_aux_reg;
    logic              last_reg;
    logic [15:0]       cur_reg;
    logic              m_tvalid_reg;
    logic [47:0]       m_tdata_reg;
    logic              m_tlast_reg;

    logic        in_xfer;
    logic        identity;
    logic        use_aux;
    logic [15:0] cur_angle;
    logic        xf_start;
    logic        xf_done;
    logic [15:0] xf_result;
    logic        out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign identity = (xcfg_reg.rot_xx == ONE_Q14) && (xcfg_reg.rot_xy == '0) &&
                      (xcfg_reg.rot_yx == '0) && (xcfg_reg.rot_yy == ONE_Q14) &&
                      (xcfg_reg.shift_x == '0) && (xcfg_reg.shift_y == '0);
    assign use_aux   = s_tuser && (s_tdata[15:0] != RANGE_INVALID);
    assign cur_angle = (beam_count_reg == '0) ? angle_start_reg : beam_angle_reg;
    assign xf_start  = in_xfer && use_aux && !identity;

    rstm_xform u_xform (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (xf_start),
        .range_in (s_tdata[15:0]),
        .angle    (cur_angle),
        .cfg      (xcfg_reg),
        .done     (xf_done),
        .result   (xf_result)
    );

    // merge and closest-reading tracking
    logic [15:0] main_cand;
    logic [15:0] merged;
    logic        better;
    logic [15:0] near_range;
    logic [15:0] near_angle;

    always_comb
    begin
        main_cand = ((main_reg != RANGE_INVALID) && (main_reg != '0)) ? main_reg : '0;
        if (use_aux_reg && (aux_t_reg != '0) &&
            ((main_cand == '0) || (aux_t_reg < main_cand)))
        begin
            merged = aux_t_reg;
        end
        else
        begin
            merged = main_cand;
        end
        better     = (merged < best_range_reg);
        near_range = better ? merged : best_range_reg;
        near_angle = better ? cur_reg : best_angle_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg  <= '0;
            angle_step_reg   <= '0;
            xcfg_reg.rot_xx  <= ONE_Q14;
            xcfg_reg.rot_xy  <= '0;
            xcfg_reg.rot_yx  <= '0;
            xcfg_reg.rot_yy  <= ONE_Q14;
            xcfg_reg.shift_x <= '0;
            xcfg_reg.shift_y <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ANGLE_START: angle_start_reg  <= cfg_data;
                REG_ANGLE_STEP:  angle_step_reg   <= cfg_data;
                REG_ROT_XX:      xcfg_reg.rot_xx  <= cfg_data;
                REG_ROT_XY:      xcfg_reg.rot_xy  <= cfg_data;
                REG_ROT_YX:      xcfg_reg.rot_yx  <= cfg_data;
                REG_ROT_YY:      xcfg_reg.rot_yy  <= cfg_data;
                REG_SHIFT_X:     xcfg_reg.shift_x <= cfg_data;
                REG_SHIFT_Y:     xcfg_reg.shift_y <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // beam sequencer, scan state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            beam_count_reg <= '0;
            beam_angle_reg <= '0;
            best_range_reg <= RANGE_INVALID;
            best_angle_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_FINISH) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= xf_start ? S_BUSY : S_FINISH;
                    end
                end
                S_BUSY:
                begin
                    if (xf_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (last_reg)
                        begin
                            beam_count_reg <= '0;
                            beam_angle_reg <= angle_start_reg;
                            best_range_reg <= RANGE_INVALID;
                            best_angle_reg <= '0;
                        end
                        else
                        begin
                            beam_count_reg <= (beam_count_reg == BEAM_LAST) ?
                                              '0 : beam_count_reg + 1'b1;
                            beam_angle_reg <= cur_reg + angle_step_reg;
                            if (better)
                            begin
                                best_range_reg <= merged;
                                best_angle_reg <= cur_reg;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // beam payload and result data
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            main_reg    <= s_tdata[31:16];
            aux_t_reg   <= s_tdata[15:0];
            use_aux_reg <= use_aux;
            last_reg    <= s_tlast;
            cur_reg     <= cur_angle;
        end
        else if ((state_reg == S_BUSY) && xf_done)
        begin
            aux_t_reg <= xf_result;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            m_tdata_reg[15:0]  <= merged;
            m_tdata_reg[31:16] <= last_reg ? near_range : '0;
            m_tdata_reg[47:32] <= last_reg ? near_angle : '0;
            m_tlast_reg        <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_merged_not_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] != RANGE_INVALID)
        else $error("merged range carries the invalid code");

    a_nearest_zero_mid_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> m_tdata[47:16] == '0)
        else $error("nearest fields set before end of scan");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        xf_done |-> state_reg == S_BUSY)
        else $error("transform finished without a pending beam");

    a_xform_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        xf_start |=> state_reg == S_BUSY)
        else $error("transform started but sequencer not waiting");

endmodule
